// ----- rtl/fgs_pkg.sv -----
package fgs_pkg;

	localparam int MUL_LAT  = 2;
	localparam int SQRT_LAT = 64;
	localparam int DIV_LAT  = 64;

	// Pipeline slot at which each intermediate result is held in a register.
	localparam int T_SQA  = MUL_LAT;
	localparam int T_MOM  = T_SQA + SQRT_LAT;
	localparam int T_PQM  = T_MOM + MUL_LAT;
	localparam int T_PQ   = T_PQM + 1;
	localparam int T_SUM  = T_PQ + 1;
	localparam int T_VD   = T_SUM + DIV_LAT;
	localparam int T_VC   = T_VD + 1;
	localparam int T_VCSQ = T_VC + MUL_LAT;
	localparam int T_VCS  = T_VCSQ + 1;
	localparam int T_VCM  = T_VCS + SQRT_LAT;
	localparam int T_VPM  = T_VCM + MUL_LAT;
	localparam int T_VL   = T_VPM + 1;
	localparam int T_VLSQ = T_VL + MUL_LAT;
	localparam int T_S    = T_VLSQ + 1;
	localparam int T_MAG  = T_S + SQRT_LAT;
	localparam int T_DD   = T_MAG + DIV_LAT;
	localparam int T_OUT  = T_DD + 1;

	localparam int A_W = 41;
	localparam logic [55:0] THRESH_Q31 = 56'd429496729600;
	localparam logic [31:0] MASS_RATIO_Q32 = 32'd4258071465;
	localparam logic [63:0] ONE_Q32 = 64'h1_0000_0000;
	localparam logic [A_W-1:0] A_RESET = A_W'((64'd66060 * 64'd4258071465) >> 16);
	localparam logic [63:0] INT64_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [55:0] MASK56 = '1;
	localparam logic signed [63:0] DIR_ONE = 64'sd1073741824;

	typedef logic [2:0][31:0] vec32_t;
	typedef logic [2:0][63:0] vec64_t;

	typedef struct packed {
		logic [55:0]        neutron_energy;
		logic signed [31:0] dir_in_x;
		logic signed [31:0] dir_in_y;
		logic signed [31:0] dir_in_z;
		logic [55:0]        target_energy_sample;
		logic signed [31:0] target_dir_x;
		logic signed [31:0] target_dir_y;
		logic signed [31:0] target_dir_z;
		logic signed [31:0] cm_dir_x;
		logic signed [31:0] cm_dir_y;
		logic signed [31:0] cm_dir_z;
	} in_t;

	typedef struct packed {
		logic [55:0]        energy_out;
		logic signed [31:0] dir_out_x;
		logic signed [31:0] dir_out_y;
		logic signed [31:0] dir_out_z;
		logic               zero_speed;
	} out_t;

	function automatic logic [63:0] mag64(input logic [63:0] v);
		return v[63] ? (64'd0 - v) : v;
	endfunction

	function automatic logic [31:0] mag32(input logic [31:0] v);
		return v[31] ? (32'd0 - v) : v;
	endfunction

	// Caps a magnitude at the largest positive value, then applies the sign.
	function automatic logic [63:0] sgn_apply(input logic [63:0] m, input logic neg);
		logic [63:0] c;
		c = m[63] ? INT64_MAX : m;
		return neg ? (64'd0 - c) : c;
	endfunction

	// Q.32 times Q1.30 product, truncated toward zero and saturated.
	function automatic logic [63:0] mulq(input logic [127:0] p, input logic neg);
		logic [127:0] s;
		logic [63:0]  m;
		s = p >> 30;
		m = (s[127:64] != 64'd0) ? '1 : s[63:0];
		return sgn_apply(m, neg);
	endfunction

endpackage

// ----- rtl/fgs_mul.sv -----
module fgs_mul (
	input  logic         clk,
	input  logic         en,
	input  logic [63:0]  a,
	input  logic [63:0]  b,
	output logic [127:0] p
);

	logic [63:0] p00_s1, p01_s1, p10_s1, p11_s1;

	// Four 32 by 32 partial products, then one registered sum.
	always_ff @(posedge clk) begin
		if (en) begin
			p00_s1 <= a[31:0] * b[31:0];
			p01_s1 <= a[31:0] * b[63:32];
			p10_s1 <= a[63:32] * b[31:0];
			p11_s1 <= a[63:32] * b[63:32];
			p <= {64'd0, p00_s1} + {32'd0, p01_s1, 32'd0} + {32'd0, p10_s1, 32'd0}
				+ {p11_s1, 64'd0};
		end
	end

endmodule

// ----- rtl/fgs_sqrt.sv -----
module fgs_sqrt (
	input  logic         clk,
	input  logic         en,
	input  logic [127:0] rad,
	output logic [63:0]  root
);

	logic [65:0]  rem_s  [fgs_pkg::SQRT_LAT];
	logic [63:0]  root_s [fgs_pkg::SQRT_LAT];
	logic [127:0] rad_s  [fgs_pkg::SQRT_LAT];

	// One result bit per stage: two radicand bits enter the remainder each step.
	for (genvar k = 0; k < fgs_pkg::SQRT_LAT; k++) begin : g_step
		logic [65:0]  prem;
		logic [63:0]  proot;
		logic [127:0] prad;
		logic [67:0]  work;
		logic [67:0]  trial;
		if (k == 0) begin : g_first
			assign prem  = '0;
			assign proot = '0;
			assign prad  = rad;
		end else begin : g_next
			assign prem  = rem_s[k-1];
			assign proot = root_s[k-1];
			assign prad  = rad_s[k-1];
		end
		assign work  = {prem, prad[127:126]};
		assign trial = {2'b00, proot, 2'b01};
		always_ff @(posedge clk) begin
			if (en) begin
				if (work >= trial) begin
					rem_s[k]  <= 66'(work - trial);
					root_s[k] <= {proot[62:0], 1'b1};
				end else begin
					rem_s[k]  <= work[65:0];
					root_s[k] <= {proot[62:0], 1'b0};
				end
				rad_s[k] <= {prad[125:0], 2'b00};
			end
		end
	end

	assign root = root_s[fgs_pkg::SQRT_LAT-1];

endmodule

// ----- rtl/fgs_div.sv -----
module fgs_div (
	input  logic         clk,
	input  logic         en,
	input  logic [127:0] num,
	input  logic [63:0]  den,
	output logic [63:0]  quo
);

	logic [63:0] rem_s [fgs_pkg::DIV_LAT];
	logic [63:0] quo_s [fgs_pkg::DIV_LAT];
	logic [63:0] lo_s  [fgs_pkg::DIV_LAT];
	logic [63:0] den_s [fgs_pkg::DIV_LAT];

	// Restoring division, one quotient bit per stage. The carry out of the
	// shifted remainder forces a subtract so the remainder never overflows.
	for (genvar k = 0; k < fgs_pkg::DIV_LAT; k++) begin : g_step
		logic [63:0] prem, pquo, plo, pden, r;
		logic        take;
		if (k == 0) begin : g_first
			assign prem = num[127:64];
			assign pquo = '0;
			assign plo  = num[63:0];
			assign pden = den;
		end else begin : g_next
			assign prem = rem_s[k-1];
			assign pquo = quo_s[k-1];
			assign plo  = lo_s[k-1];
			assign pden = den_s[k-1];
		end
		assign r    = {prem[62:0], plo[63]};
		assign take = prem[63] || (r >= pden);
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k] <= take ? (r - pden) : r;
				quo_s[k] <= {pquo[62:0], take};
				lo_s[k]  <= {plo[62:0], 1'b0};
				den_s[k] <= pden;
			end
		end
	end

	assign quo = quo_s[fgs_pkg::DIV_LAT-1];

endmodule

// ----- rtl/free_gas_elastic_scatter.sv -----
// Throughput: one collision per cycle; every stage is registered and the
// whole pipeline advances together whenever the output register is free.
// Reset clears every valid bit and loads the default target mass ratio;
// data registers are not reset.
module free_gas_elastic_scatter (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  fgs_pkg::in_t    in_data,
	output logic            out_valid,
	input  logic            out_ready,
	output fgs_pkg::out_t   out_data,
	input  logic            cfg_we,
	input  logic [24:0]     cfg_wdata
);

	// The pipeline moves as one: it advances when the output register is
	// empty or its beat is being taken. Bubbles are carried as clear valid bits.
	logic adv;
	assign adv       = out_ready || !out_valid;
	assign in_ready  = adv;

	// The configured weight is kept already scaled by the amu to neutron mass ratio,
	// as a Q.32 value. Writes must come only while the pipeline is empty; the block does not enforce it.
	logic [fgs_pkg::A_W-1:0] a_q;
	logic [63:0]             den64;
	assign den64 = fgs_pkg::ONE_Q32 + 64'(a_q);

	logic v_s [1:fgs_pkg::T_OUT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_q <= fgs_pkg::A_RESET;
			for (int k = 1; k <= fgs_pkg::T_OUT; k++) v_s[k] <= 1'b0;
		end else begin
			if (cfg_we) begin
				a_q <= fgs_pkg::A_W'((57'(cfg_wdata) * 57'(fgs_pkg::MASS_RATIO_Q32)) >> 16);
			end
			if (adv) begin
				v_s[1] <= in_valid;
				for (int k = 2; k <= fgs_pkg::T_OUT; k++) v_s[k] <= v_s[k-1];
			end
		end
	end

	assign out_valid = v_s[fgs_pkg::T_OUT];

	fgs_pkg::vec32_t din, tdin, cmin;
	assign din  = {in_data.dir_in_z, in_data.dir_in_y, in_data.dir_in_x};
	assign tdin = {in_data.target_dir_z, in_data.target_dir_y, in_data.target_dir_x};
	assign cmin = {in_data.cm_dir_z, in_data.cm_dir_y, in_data.cm_dir_x};

	// Stage one: the target momentum term needs A times the sampled target
	// energy. The neutron energy passes through as many registers as the
	// multiplier has stages, so both square roots start together.
	logic [127:0] prod_et;
	fgs_mul u_mul_et (
		.clk (clk), .en (adv),
		.a   (64'(a_q)), .b (64'(in_data.target_energy_sample)),
		.p   (prod_et)
	);

	logic [55:0]     e_s   [1:fgs_pkg::T_SQA];
	logic            low_s [1:fgs_pkg::T_MOM];
	fgs_pkg::vec32_t din_s [1:fgs_pkg::T_PQM];
	fgs_pkg::vec32_t tdr_s [1:fgs_pkg::T_PQM];
	fgs_pkg::vec32_t cm_s  [1:fgs_pkg::T_VPM];

	always_ff @(posedge clk) begin
		if (adv) begin
			e_s[1]   <= in_data.neutron_energy;
			low_s[1] <= in_data.neutron_energy < fgs_pkg::THRESH_Q31;
			din_s[1] <= din;
			tdr_s[1] <= tdin;
			cm_s[1]  <= cmin;
			for (int k = 2; k <= fgs_pkg::T_SQA; k++) e_s[k] <= e_s[k-1];
			for (int k = 2; k <= fgs_pkg::T_MOM; k++) low_s[k] <= low_s[k-1];
			for (int k = 2; k <= fgs_pkg::T_PQM; k++) begin
				din_s[k] <= din_s[k-1];
				tdr_s[k] <= tdr_s[k-1];
			end
			for (int k = 2; k <= fgs_pkg::T_VPM; k++) cm_s[k] <= cm_s[k-1];
		end
	end

	// Neutron speed sqrt(E) and target momentum sqrt(A Et), in Q.32.
	logic [63:0] sn_root, mom_root, mom;
	fgs_sqrt u_sqrt_sn (
		.clk (clk), .en (adv),
		.rad ({39'd0, e_s[fgs_pkg::T_SQA], 33'd0}),
		.root(sn_root)
	);
	fgs_sqrt u_sqrt_mom (
		.clk (clk), .en (adv),
		.rad ({prod_et[126:0], 1'b0}),
		.root(mom_root)
	);
	// At or above the threshold the target is taken to be at rest.
	assign mom = low_s[fgs_pkg::T_MOM] ? mom_root : 64'd0;

	// Lab-frame neutron velocity p and target velocity term q per axis.
	logic [127:0] pm [3];
	logic [127:0] qm [3];
	for (genvar i = 0; i < 3; i++) begin : g_pq
		fgs_mul u_mul_p (
			.clk (clk), .en (adv), .a (sn_root),
			.b   (64'(fgs_pkg::mag32(din_s[fgs_pkg::T_MOM][i]))), .p (pm[i])
		);
		fgs_mul u_mul_q (
			.clk (clk), .en (adv), .a (mom),
			.b   (64'(fgs_pkg::mag32(tdr_s[fgs_pkg::T_MOM][i]))), .p (qm[i])
		);
	end

	fgs_pkg::vec64_t p_d [fgs_pkg::T_PQ:fgs_pkg::T_VD];
	fgs_pkg::vec64_t q_s69;
	fgs_pkg::vec64_t sum_s70;
	logic [2:0]      sg_d [fgs_pkg::T_SUM+1:fgs_pkg::T_VD];

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				p_d[fgs_pkg::T_PQ][i] <= fgs_pkg::mulq(pm[i], din_s[fgs_pkg::T_PQM][i][31]);
				q_s69[i] <= fgs_pkg::mulq(qm[i], tdr_s[fgs_pkg::T_PQM][i][31]);
				sum_s70[i] <= p_d[fgs_pkg::T_PQ][i] + q_s69[i];
				sg_d[fgs_pkg::T_SUM+1][i] <= sum_s70[i][63];
			end
			for (int k = fgs_pkg::T_PQ + 1; k <= fgs_pkg::T_VD; k++) p_d[k] <= p_d[k-1];
			for (int k = fgs_pkg::T_SUM + 2; k <= fgs_pkg::T_VD; k++) sg_d[k] <= sg_d[k-1];
		end
	end

	// Centre-of-mass velocity: (p + q) / (1 + A), rounded toward zero.
	logic [63:0] vq [3];
	for (genvar i = 0; i < 3; i++) begin : g_vcm
		fgs_div u_div_vcm (
			.clk (clk), .en (adv),
			.num ({32'd0, fgs_pkg::mag64(sum_s70[i]), 32'd0}),
			.den (den64),
			.quo (vq[i])
		);
	end

	fgs_pkg::vec64_t vcm_d [fgs_pkg::T_VC:fgs_pkg::T_VPM];
	fgs_pkg::vec64_t vc_s135;
	fgs_pkg::vec64_t vcm_now;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			vcm_now[i] = fgs_pkg::sgn_apply(vq[i], sg_d[fgs_pkg::T_VD][i]);
		end
	end

	// CM-frame velocity vc = p - Vcm, whose length is the CM speed.
	always_ff @(posedge clk) begin
		if (adv) begin
			vcm_d[fgs_pkg::T_VC] <= vcm_now;
			for (int i = 0; i < 3; i++) vc_s135[i] <= p_d[fgs_pkg::T_VD][i] - vcm_now[i];
			for (int k = fgs_pkg::T_VC + 1; k <= fgs_pkg::T_VPM; k++) vcm_d[k] <= vcm_d[k-1];
		end
	end

	logic [127:0] vcsq [3];
	for (genvar i = 0; i < 3; i++) begin : g_vcsq
		fgs_mul u_mul_vcsq (
			.clk (clk), .en (adv),
			.a   (fgs_pkg::mag64(vc_s135[i])), .b (fgs_pkg::mag64(vc_s135[i])),
			.p   (vcsq[i])
		);
	end

	logic [127:0] vcs_s138;
	always_ff @(posedge clk) begin
		if (adv) vcs_s138 <= vcsq[0] + vcsq[1] + vcsq[2];
	end

	logic [63:0] vcmag;
	fgs_sqrt u_sqrt_vc (.clk (clk), .en (adv), .rad (vcs_s138), .root (vcmag));

	// The CM speed is laid along the sampled CM direction, then Vcm is added back.
	logic [127:0] vpm [3];
	for (genvar i = 0; i < 3; i++) begin : g_vp
		fgs_mul u_mul_vp (
			.clk (clk), .en (adv), .a (vcmag),
			.b   (64'(fgs_pkg::mag32(cm_s[fgs_pkg::T_VCM][i]))), .p (vpm[i])
		);
	end

	fgs_pkg::vec64_t vl_d [fgs_pkg::T_VL:fgs_pkg::T_DD];
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				vl_d[fgs_pkg::T_VL][i] <= fgs_pkg::mulq(vpm[i], cm_s[fgs_pkg::T_VPM][i][31])
					+ vcm_d[fgs_pkg::T_VPM][i];
			end
			for (int k = fgs_pkg::T_VL + 1; k <= fgs_pkg::T_DD; k++) vl_d[k] <= vl_d[k-1];
		end
	end

	logic [127:0] vlsq [3];
	for (genvar i = 0; i < 3; i++) begin : g_vlsq
		fgs_mul u_mul_vlsq (
			.clk (clk), .en (adv),
			.a   (fgs_pkg::mag64(vl_d[fgs_pkg::T_VL][i])),
			.b   (fgs_pkg::mag64(vl_d[fgs_pkg::T_VL][i])),
			.p   (vlsq[i])
		);
	end

	// Outgoing speed squared in Q.64; the energy is that sum shifted down to
	// Q25.31 and saturated.
	logic [127:0] s_s208;
	logic [127:0] s_shr;
	logic [55:0]  e_sat;
	assign s_shr = s_s208 >> 33;
	assign e_sat = (s_shr[127:56] != 72'd0) ? fgs_pkg::MASK56 : s_shr[55:0];

	always_ff @(posedge clk) begin
		if (adv) s_s208 <= vlsq[0] + vlsq[1] + vlsq[2];
	end

	logic [63:0] mag;
	fgs_sqrt u_sqrt_mag (.clk (clk), .en (adv), .rad (s_s208), .root (mag));

	logic [55:0] eout_d [fgs_pkg::T_S+1:fgs_pkg::T_DD];
	logic        zf_d   [fgs_pkg::T_MAG+1:fgs_pkg::T_DD];

	always_ff @(posedge clk) begin
		if (adv) begin
			eout_d[fgs_pkg::T_S+1] <= e_sat;
			zf_d[fgs_pkg::T_MAG+1] <= (mag == 64'd0);
			for (int k = fgs_pkg::T_S + 2; k <= fgs_pkg::T_DD; k++) eout_d[k] <= eout_d[k-1];
			for (int k = fgs_pkg::T_MAG + 2; k <= fgs_pkg::T_DD; k++) zf_d[k] <= zf_d[k-1];
		end
	end

	// Unit direction: each component divided by the outgoing speed. A zero
	// speed gives a meaningless quotient here; it is replaced at the output.
	logic [63:0] dq [3];
	for (genvar i = 0; i < 3; i++) begin : g_dir
		fgs_div u_div_dir (
			.clk (clk), .en (adv),
			.num ({34'd0, fgs_pkg::mag64(vl_d[fgs_pkg::T_MAG][i]), 30'd0}),
			.den (mag),
			.quo (dq[i])
		);
	end

	logic [2:0][31:0] dclamp;
	always_comb begin
		logic signed [63:0] ds;
		for (int i = 0; i < 3; i++) begin
			ds = $signed(fgs_pkg::sgn_apply(dq[i], vl_d[fgs_pkg::T_DD][i][63]));
			if (ds > fgs_pkg::DIR_ONE) ds = fgs_pkg::DIR_ONE;
			if (ds < -fgs_pkg::DIR_ONE) ds = -fgs_pkg::DIR_ONE;
			dclamp[i] = zf_d[fgs_pkg::T_DD] ? 32'd0 : ds[31:0];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_data.energy_out <= eout_d[fgs_pkg::T_DD];
			out_data.dir_out_x  <= dclamp[0];
			out_data.dir_out_y  <= dclamp[1];
			out_data.dir_out_z  <= dclamp[2];
			out_data.zero_speed <= zf_d[fgs_pkg::T_DD];
		end
	end

	// A zero outgoing speed always comes with a zero energy and direction.
	a_zero_speed: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.zero_speed |->
			out_data.energy_out == 56'd0 && out_data.dir_out_x == 32'sd0
			&& out_data.dir_out_y == 32'sd0 && out_data.dir_out_z == 32'sd0)
		else $error("zero speed beat with nonzero energy or direction");

	// Every direction cosine stays within the clamp range.
	a_dir_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |->
			out_data.dir_out_x <= 32'sd1073741824 && out_data.dir_out_x >= -32'sd1073741824
			&& out_data.dir_out_y <= 32'sd1073741824 && out_data.dir_out_y >= -32'sd1073741824
			&& out_data.dir_out_z <= 32'sd1073741824 && out_data.dir_out_z >= -32'sd1073741824)
		else $error("direction cosine outside clamp range");

	// A stalled pipeline takes no input beat and holds its first valid bit.
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready ##1 (v_s[1] == $past(v_s[1])))
		else $error("pipeline moved while stalled");

endmodule
